>>> rtl/tsd_pkg.sv
// Shared types, constants and lookup functions for the transport stream
// packet size and sync detector. No dependencies.
package tsd_pkg;

   localparam int COUNT_WIDTH  = 11;
   localparam int POS_WIDTH    = 8;
   localparam int NUM_SIZES    = 4;
   localparam int NUM_STRIDES  = 3;

   localparam int DEF_MIN_LENGTH    = 1664;
   localparam int DEF_SEARCH_WINDOW = 208;
   localparam int DEF_HEADER_OFFSET = 1320;

   localparam logic [7:0]             SYNC_BYTE   = 8'h47;
   localparam logic [31:0]            TAG_TFRC    = 32'h5446_7263;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX   = {COUNT_WIDTH{1'b1}};
   localparam logic [7:0]             REC_SIZE    = 8'd188;

   typedef logic [NUM_STRIDES-1:0] hit_mask_type;

   // what the tracker holds after the current byte has been applied
   typedef struct packed {
      logic [COUNT_WIDTH-1:0]         byte_count;
      logic                           sync_seen;
      logic [POS_WIDTH-1:0]           sync_pos;
      hit_mask_type [NUM_SIZES-1:0]   stride_hits;
      logic [31:0]                    head_tag;
   } trk_status_type;

   function automatic logic [7:0] size_of(input logic [1:0] sel);
      logic [7:0] size;
      case (sel)
         2'd0:    size = 8'd188;
         2'd1:    size = 8'd192;
         2'd2:    size = 8'd204;
         2'd3:    size = 8'd208;
         default: size = 8'd188;
      endcase
      return size;
   endfunction

   function automatic logic [4:0] skip_of(input logic [1:0] sel);
      logic [4:0] skip;
      case (sel)
         2'd0:    skip = 5'd0;
         2'd1:    skip = 5'd4;
         2'd2:    skip = 5'd16;
         2'd3:    skip = 5'd20;
         default: skip = 5'd0;
      endcase
      return skip;
   endfunction

endpackage

>>> rtl/tsd_sync_tracker.sv
// Per-buffer state: byte count, first sync anchor, stride hits and head tag.
// Depends on tsd_pkg.
module tsd_sync_tracker import tsd_pkg::*; #(
   parameter int SEARCH_WINDOW = DEF_SEARCH_WINDOW
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           step,
   input  logic [7:0]     data_byte,
   input  logic           last_byte,
   output trk_status_type status
);

   logic [COUNT_WIDTH-1:0]       count_ff, count_in;
   logic                         seen_ff, seen_in;
   logic [POS_WIDTH-1:0]         pos_ff, pos_in;
   hit_mask_type [NUM_SIZES-1:0] hits_ff, hits_in;
   logic [31:0]                  tag_ff, tag_in;

   logic                         is_sync;
   logic [COUNT_WIDTH-1:0]       target;

   assign is_sync = (data_byte == SYNC_BYTE);

   always_comb begin
      tag_in   = tag_ff;
      seen_in  = seen_ff;
      pos_in   = pos_ff;
      hits_in  = hits_ff;
      target   = '0;
      count_in = (count_ff == COUNT_MAX) ? count_ff : count_ff + 1'b1;

      if (count_ff < COUNT_WIDTH'(4)) begin
         tag_in = {tag_ff[23:0], data_byte};
      end

      if (seen_ff) begin
         // twelve independent compares against anchor + k * size
         for (int s = 0; s < NUM_SIZES; s++) begin
            for (int k = 1; k <= NUM_STRIDES; k++) begin
               target = COUNT_WIDTH'(pos_ff) + COUNT_WIDTH'(k) * COUNT_WIDTH'(size_of(2'(s)));
               if (count_ff == target && is_sync) begin
                  hits_in[s][k-1] = 1'b1;
               end
            end
         end
      end else if (count_ff < COUNT_WIDTH'(SEARCH_WINDOW) && is_sync) begin
         seen_in = 1'b1;
         pos_in  = count_ff[POS_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (step && last_byte)) begin
         count_ff <= '0;
         seen_ff  <= 1'b0;
         pos_ff   <= '0;
         hits_ff  <= '0;
         tag_ff   <= '0;
      end else if (step) begin
         count_ff <= count_in;
         seen_ff  <= seen_in;
         pos_ff   <= pos_in;
         hits_ff  <= hits_in;
         tag_ff   <= tag_in;
      end
   end

   assign status.byte_count  = count_in;
   assign status.sync_seen   = seen_in;
   assign status.sync_pos    = pos_in;
   assign status.stride_hits = hits_in;
   assign status.head_tag    = tag_in;

endmodule

>>> rtl/ts_packet_size_sync_detect.sv
// Top level of the transport stream packet size and sync detector.
// Depends on tsd_pkg and tsd_sync_tracker.
//
// Usage:
//   req channel carries one capture-buffer byte per transfer in req_tdata,
//   with req_tlast on the final byte. Nothing comes out for ordinary bytes;
//   the final byte yields exactly one rsp transfer with the framing verdict:
//   recorder tag, or first 0x47 anchor plus a packet size confirmed by sync
//   bytes at one, two and three strides. Buffers below MIN_LENGTH bytes, or
//   with no confirmed size, report all zeros.
//   rsp_tvalid rises once the last byte, held in the input register, has
//   stepped the tracker and its verdict lands in the result register.
//   Throughput: one byte per cycle, back to back, unless a last byte waits
//   on a pending verdict; each byte makes twelve combinational index compares.
//   Reset clears the byte count, the anchor and all hit masks; state also
//   returns to this reset value after every verdict.
//   If the receiver stalls with a verdict pending, the block keeps taking
//   bytes until the next last byte reaches the input register, then holds.
module ts_packet_size_sync_detect import tsd_pkg::*; #(
   parameter int MIN_LENGTH    = DEF_MIN_LENGTH,
   parameter int SEARCH_WINDOW = DEF_SEARCH_WINDOW,
   parameter int HEADER_OFFSET = DEF_HEADER_OFFSET
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // last_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // [0] found, [1] recorder_header,
                                    // [12:2] start_offset, [17:13] prefix_skip,
                                    // [25:18] packet_size, [31:26] zero
);

   logic                   in_valid_ff;
   logic [7:0]             in_byte_ff;
   logic                   in_last_ff;
   logic                   out_free;
   logic                   advance;
   logic                   step;
   logic                   rsp_valid_ff;

   trk_status_type         status;

   logic                   found_in, found_ff;
   logic                   rec_in, rec_ff;
   logic [COUNT_WIDTH-1:0] start_in, start_ff;
   logic [4:0]             skip_in, skip_ff;
   logic [7:0]             size_in, size_ff;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign advance    = !in_valid_ff || !in_last_ff || out_free;
   assign step       = in_valid_ff && advance;
   assign req_tready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (advance) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   tsd_sync_tracker #(
      .SEARCH_WINDOW (SEARCH_WINDOW)
   ) u_tracker (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .data_byte (in_byte_ff),
      .last_byte (in_last_ff),
      .status    (status)
   );

   // verdict from the state as it stands after the last byte
   always_comb begin
      found_in = 1'b0;
      rec_in   = 1'b0;
      start_in = '0;
      skip_in  = '0;
      size_in  = '0;
      if (status.byte_count >= COUNT_WIDTH'(MIN_LENGTH)) begin
         if (status.head_tag == TAG_TFRC) begin
            found_in = 1'b1;
            rec_in   = 1'b1;
            start_in = COUNT_WIDTH'(HEADER_OFFSET);
            size_in  = REC_SIZE;
         end else if (status.sync_seen) begin
            // walk downward so the smallest matching size wins
            for (int s = NUM_SIZES - 1; s >= 0; s--) begin
               if (&status.stride_hits[s]) begin
                  found_in = 1'b1;
                  skip_in  = skip_of(2'(s));
                  size_in  = size_of(2'(s));
                  if (COUNT_WIDTH'(status.sync_pos) >= COUNT_WIDTH'(skip_of(2'(s)))) begin
                     start_in = COUNT_WIDTH'(status.sync_pos)
                              - COUNT_WIDTH'(skip_of(2'(s)));
                  end else begin
                     start_in = COUNT_WIDTH'(status.sync_pos)
                              + COUNT_WIDTH'(size_of(2'(s)))
                              - COUNT_WIDTH'(skip_of(2'(s)));
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step && in_last_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step && in_last_ff) begin
         found_ff <= found_in;
         rec_ff   <= rec_in;
         start_ff <= start_in;
         skip_ff  <= skip_in;
         size_ff  <= size_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, size_ff, skip_ff, start_ff, rec_ff, found_ff};

   // a found verdict always names one of the four sizes
   a_found_size: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && found_ff) |-> (size_ff == 8'd188 || size_ff == 8'd192 ||
                                      size_ff == 8'd204 || size_ff == 8'd208))
      else $error("found verdict with bad packet size");

   // no framing means every field reads zero
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !found_ff) |->
         (!rec_ff && start_ff == '0 && skip_ff == '0 && size_ff == '0))
      else $error("miss verdict with nonzero fields");

   // recorder verdict is fixed framing
   a_rec_fixed: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rec_ff) |->
         (found_ff && skip_ff == '0 && size_ff == REC_SIZE))
      else $error("recorder verdict inconsistent");

   // a held last byte never steps while the pending verdict is untaken
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready && in_valid_ff && in_last_ff) |-> !step)
      else $error("verdict overrun");

endmodule
